// ----- hdl/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptb_pkg
// shared types and codes of the periodic timer bank
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_RESULTS   = 16;

  localparam int ID_W  = 32;
  localparam int PER_W = 24;
  // table entry: {ident, period, remaining}
  localparam int ENTRY_W = ID_W + PER_W + PER_W;

  // item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_CREATE  = 2'd1;
  localparam logic [1:0] KIND_DESTROY = 2'd2;

  // result status codes
  localparam logic [2:0] ST_CREATED   = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DESTROYED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [2:0]        status;
    logic [ID_W-1:0]   ident;
    logic              last;
  } res_t;

endpackage

// ----- hdl/ptb_ram.sv -----
// ----------------------------------------------------------------------------
// ptb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/ptb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptb_ctrl
// slot sequencer: valid bits, serial counter and read-modify-write of the
// timer table
// ----------------------------------------------------------------------------
module ptb_ctrl #(
  parameter int NUM_SLOTS = ptb_pkg::NUM_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic [ptb_pkg::PER_W-1:0] in_interval,
  input  logic [ptb_pkg::ID_W-1:0]  in_timer_id,
  input  logic                     out_free,
  output ptb_pkg::res_t            res
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(ptb_pkg::MAX_RESULTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CREATE = 5'b00010,
    S_READ   = 5'b00100,
    S_EVAL   = 5'b01000,
    S_FLUSH  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [IDX_W-1:0]              idx, idx_next;
  logic [1:0]                    kind, kind_next;
  logic [ptb_pkg::PER_W-1:0]     interval, interval_next;
  logic [ptb_pkg::ID_W-1:0]      req_id, req_id_next;
  logic [ptb_pkg::ID_W-1:0]      serial, serial_next;
  logic [NUM_SLOTS-1:0]          slot_valid, slot_valid_next;
  logic                          pend_valid, pend_valid_next;
  logic [ptb_pkg::ID_W-1:0]      pend_id, pend_id_next;
  logic [CNT_W-1:0]              cnt, cnt_next;

  // table port
  logic                          ram_we, ram_re;
  logic [IDX_W-1:0]              ram_waddr;
  logic [ptb_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;

  ptb_ram #(
    .WIDTH (ptb_pkg::ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // entry fields of the slot under evaluation
  logic [ptb_pkg::ID_W-1:0]  ent_ident;
  logic [ptb_pkg::PER_W-1:0] ent_period, ent_rem, per;
  logic                      cur_valid, due, take, hit, at_end;

  assign ent_ident  = ram_rdata[ptb_pkg::ENTRY_W-1 -: ptb_pkg::ID_W];
  assign ent_period = ram_rdata[2*ptb_pkg::PER_W-1 -: ptb_pkg::PER_W];
  assign ent_rem    = ram_rdata[ptb_pkg::PER_W-1:0];
  assign cur_valid  = slot_valid[idx];
  assign due        = (ent_rem <= ptb_pkg::PER_W'(1));
  assign take       = cur_valid && due && (cnt < CNT_W'(ptb_pkg::MAX_RESULTS));
  assign hit        = cur_valid && (ent_ident == req_id);
  assign at_end     = (idx == LAST_IDX);
  assign per        = (interval == '0) ? ptb_pkg::PER_W'(1) : interval;

  // lowest free slot
  logic [IDX_W-1:0] free_idx;
  logic             any_free;

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    kind_next       = kind;
    interval_next   = interval;
    req_id_next     = req_id;
    serial_next     = serial;
    slot_valid_next = slot_valid;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    cnt_next        = cnt;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = {ent_ident, ent_period,
                       due ? ent_period : ent_rem - ptb_pkg::PER_W'(1)};
    res             = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_next       = in_kind;
          interval_next   = in_interval;
          req_id_next     = in_timer_id;
          idx_next        = '0;
          cnt_next        = '0;
          pend_valid_next = 1'b0;
          case (in_kind)
            ptb_pkg::KIND_TICK:    state_next = S_READ;
            ptb_pkg::KIND_CREATE:  state_next = S_CREATE;
            ptb_pkg::KIND_DESTROY: state_next = S_READ;
            default:               state_next = S_IDLE;
          endcase
        end
      end

      S_CREATE: begin
        if (out_free) begin
          res.valid = 1'b1;
          res.last  = 1'b1;
          if (any_free) begin
            ram_we                    = 1'b1;
            ram_waddr                 = free_idx;
            ram_wdata                 = {serial, per, per};
            slot_valid_next[free_idx] = 1'b1;
            res.status                = ptb_pkg::ST_CREATED;
            res.ident                 = serial;
            serial_next               = serial + 1'b1;
          end else begin
            res.status = ptb_pkg::ST_FULL;
          end
          state_next = S_IDLE;
        end
      end

      S_READ: begin
        ram_re     = 1'b1;
        state_next = S_EVAL;
      end

      S_EVAL: begin
        if (kind == ptb_pkg::KIND_TICK) begin
          // a new due timer pushes the held one out, which needs the output free
          if (!(take && pend_valid && !out_free)) begin
            ram_we = cur_valid;
            if (take) begin
              if (pend_valid) begin
                res.valid  = 1'b1;
                res.status = ptb_pkg::ST_EXPIRED;
                res.ident  = pend_id;
              end
              pend_valid_next = 1'b1;
              pend_id_next    = ent_ident;
              cnt_next        = cnt + 1'b1;
            end
            if (at_end) begin
              state_next = S_FLUSH;
            end else begin
              idx_next   = idx + 1'b1;
              state_next = S_READ;
            end
          end
        end else begin
          if (hit || at_end) begin
            if (out_free) begin
              res.valid  = 1'b1;
              res.last   = 1'b1;
              res.ident  = req_id;
              res.status = hit ? ptb_pkg::ST_DESTROYED : ptb_pkg::ST_NOT_FOUND;
              if (hit) begin
                slot_valid_next[idx] = 1'b0;
              end
              state_next = S_IDLE;
            end
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_READ;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          res.valid       = 1'b1;
          res.status      = ptb_pkg::ST_EXPIRED;
          res.ident       = pend_id;
          res.last        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      serial     <= '0;
      slot_valid <= '0;
      pend_valid <= 1'b0;
      cnt        <= '0;
      idx        <= '0;
    end else begin
      state      <= state_next;
      serial     <= serial_next;
      slot_valid <= slot_valid_next;
      pend_valid <= pend_valid_next;
      cnt        <= cnt_next;
      idx        <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    kind     <= kind_next;
    interval <= interval_next;
    req_id   <= req_id_next;
    pend_id  <= pend_id_next;
  end

endmodule

// ----- hdl/periodic_timer_bank_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_bank_unit
// bank of periodic timers: create, destroy and tick items, expiries out
// ----------------------------------------------------------------------------
//
//   channel  | dir | tdata                         | tuser       | tlast
//   ---------+-----+-------------------------------+-------------+--------
//   s_*      | in  | [23:0] interval [55:24] id    | [1:0] kind  | -
//   m_*      | out | [31:0] timer_id_res           | [2:0] status| last
//
// - per item: create writes the lowest free slot, and its result is
//   registered from the create state once the output is free; destroy reads
//   the table one slot at a time and stops at the first hit or the last slot;
//   a tick always sweeps every slot (read, then evaluate and write back)
//   followed by a flush state; the single read port of the table makes the
//   sweep go slot by slot
// - one transaction is worked on at a time; s_tready is high only when idle
// - reset clears the valid bits and the serial counter at once, no sweep
// - a stalled m_* side holds the sequencer in place; the output register lets
//   the next item be accepted while the final result waits
// ----------------------------------------------------------------------------
module periodic_timer_bank_unit #(
  parameter int NUM_SLOTS = ptb_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [23:0] interval, [55:24] timer_id
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] timer_id_res
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast
);

  ptb_pkg::res_t res;
  logic          out_free;

  // output register may be loaded when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  ptb_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_kind     (s_tuser),
    .in_interval (s_tdata[23:0]),
    .in_timer_id (s_tdata[55:24]),
    .out_free    (out_free),
    .res         (res)
  );

  // result register: the sequencer only offers a result when out_free is high
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= res.ident;
      m_tuser <= res.status;
      m_tlast <= res.last;
    end
  end

  // ---------------------------------------------------------------- checks

  // create and destroy answer with exactly one result, so it is always last
  a_single_last : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ptb_pkg::ST_EXPIRED) |-> m_tlast)
    else $error("create/destroy result without last");

  // the sequencer never offers a result while idle
  a_idle_quiet : assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !res.valid)
    else $error("result offered while idle");

  // a result is never offered into a full, stalled output register
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    res.valid |-> out_free)
    else $error("result would overwrite a pending transaction");

  // an accepted create or destroy keeps the block busy for the next cycle
  a_busy_after : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == ptb_pkg::KIND_CREATE || s_tuser == ptb_pkg::KIND_DESTROY)
    |=> !s_tready)
    else $error("ready right after create/destroy");

endmodule

// ----- tb/sv/periodic_timer_bank_unit_test.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_bank_unit_test
// self-checking bench for the periodic timer bank: directed create, destroy,
// tick and bank-full sequences, then random traffic under three idle mixes;
// every result transaction is checked against an in-bench copy of the bank
// ----------------------------------------------------------------------------
module periodic_timer_bank_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = ptb_pkg::NUM_SLOTS_DEF;
  // kind code the block has to ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // settle time after the last expected result (one full sweep and margin)
  localparam int DRAIN_CYCLES = 4 * NUM_SLOTS + 8;

  // one expected result transaction
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ident;
    logic        last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // [23:0] interval, [55:24] timer_id
  logic [1:0]  s_tuser = '0;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] timer_id_res
  logic [2:0]  m_tuser;        // [2:0] status
  logic        m_tlast;

  // shadow copy of the timer table
  logic        bank_live   [NUM_SLOTS];
  logic [31:0] bank_ident  [NUM_SLOTS];
  logic [23:0] bank_period [NUM_SLOTS];
  logic [23:0] bank_left   [NUM_SLOTS];
  logic [31:0] serial_ctr;

  // results still owed by the block, oldest first
  reply_t awaited_replies[$];

  int snd_idle_pct = 27;
  int rcv_idle_pct = 54;
  int fail_count   = 0;
  int quiet_cycles = 0;

  periodic_timer_bank_unit #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // apply one accepted item to the shadow bank and queue what it must produce
  function automatic void advance_timer_bank(logic [1:0] kind, logic [23:0] interval,
                                             logic [31:0] tid);
    int slot;
    int hits;
    slot = -1;
    hits = 0;
    case (kind)
      ptb_pkg::KIND_CREATE: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (!bank_live[i] && slot < 0) slot = i;
        if (slot < 0) begin
          awaited_replies.push_back('{ptb_pkg::ST_FULL, 32'd0, 1'b1});
        end else begin
          // zero interval behaves as one tick
          bank_live[slot]   = 1'b1;
          bank_ident[slot]  = serial_ctr;
          bank_period[slot] = (interval == '0) ? 24'd1 : interval;
          bank_left[slot]   = bank_period[slot];
          awaited_replies.push_back('{ptb_pkg::ST_CREATED, serial_ctr, 1'b1});
          serial_ctr = serial_ctr + 32'd1;
        end
      end
      ptb_pkg::KIND_DESTROY: begin
        // only the lowest live slot with that id goes away
        for (int i = 0; i < NUM_SLOTS; i++)
          if (bank_live[i] && bank_ident[i] == tid && slot < 0) slot = i;
        if (slot < 0) begin
          awaited_replies.push_back('{ptb_pkg::ST_NOT_FOUND, tid, 1'b1});
        end else begin
          bank_live[slot] = 1'b0;
          awaited_replies.push_back('{ptb_pkg::ST_DESTROYED, tid, 1'b1});
        end
      end
      ptb_pkg::KIND_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (bank_live[i]) begin
            if (bank_left[i] <= 24'd1) begin
              bank_left[i] = bank_period[i];
              // due timers past the result budget still reload
              if (hits < ptb_pkg::MAX_RESULTS) begin
                awaited_replies.push_back('{ptb_pkg::ST_EXPIRED, bank_ident[i], 1'b0});
                hits++;
              end
            end else begin
              bank_left[i] = bank_left[i] - 24'd1;
            end
          end
        end
        if (hits > 0) awaited_replies[awaited_replies.size() - 1].last = 1'b1;
      end
      default: ;  // unused kind changes nothing
    endcase
  endfunction

  // id of some live timer, or a random id when the bank is empty
  function automatic logic [31:0] random_live_ident();
    int live_slots[$];
    for (int i = 0; i < NUM_SLOTS; i++)
      if (bank_live[i]) live_slots.push_back(i);
    if (live_slots.size() == 0) return $urandom();
    return bank_ident[live_slots[$urandom_range(live_slots.size() - 1)]];
  endfunction

  // present one item, hold it until the transaction happens, then predict;
  // valid is left high so back-to-back items need no second assignment
  task automatic send_item(input logic [1:0] kind, input logic [23:0] interval,
                           input logic [31:0] tid);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {tid, interval};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_timer_bank(kind, interval, tid);
  endtask

  // receiver backpressure, re-drawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // result checker: each result transaction against the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_replies.size() == 0) begin
        $error("unexpected result: status %0d timer_id_res 0x%08h last %0b",
               m_tuser, m_tdata, m_tlast);
        fail_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (m_tuser !== want.status) begin
          $error("status expected %0d actual %0d", want.status, m_tuser);
          fail_count++;
        end
        if (m_tdata !== want.ident) begin
          $error("timer_id_res expected 0x%08h actual 0x%08h", want.ident, m_tdata);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last expected %0b actual %0b", want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // hang detector: cycles in a row with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // zero interval, largest interval, short periods, then two ticks so the
  // period-one timers expire together and the period-two timer joins them
  task automatic test_create_and_expire();
    send_item(ptb_pkg::KIND_CREATE, 24'd0, 32'd0);
    send_item(ptb_pkg::KIND_CREATE, 24'hFFFFFF, 32'hFFFFFFFF);
    send_item(ptb_pkg::KIND_CREATE, 24'd1, 32'h5A5A5A5A);
    send_item(ptb_pkg::KIND_CREATE, 24'd2, 32'hA5A5A5A5);
    send_item(ptb_pkg::KIND_TICK, 24'hFFFFFF, 32'hFFFFFFFF);
    send_item(ptb_pkg::KIND_TICK, 24'd0, 32'd0);
  endtask

  // hit on a live id, miss with an all-ones id, hit on id zero
  task automatic test_destroy();
    send_item(ptb_pkg::KIND_DESTROY, 24'd0, 32'd1);
    send_item(ptb_pkg::KIND_DESTROY, 24'hFFFFFF, 32'hFFFFFFFF);
    send_item(ptb_pkg::KIND_DESTROY, 24'd0, 32'd0);
  endtask

  // the unused kind must be swallowed without a result
  task automatic test_ignored_kind();
    send_item(KIND_UNUSED, 24'hFFFFFF, 32'hFFFFFFFF);
  endtask

  // fill every free slot with period-one timers, then one create too many
  task automatic test_bank_full();
    int live;
    live = 0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (bank_live[i]) live++;
    repeat (NUM_SLOTS - live) send_item(ptb_pkg::KIND_CREATE, 24'd1, $urandom());
    send_item(ptb_pkg::KIND_CREATE, 24'd3, $urandom());
  endtask

  // full bank: one tick with all but one due, the next with every slot due
  task automatic test_mass_expiry();
    send_item(ptb_pkg::KIND_TICK, 24'($urandom()), $urandom());
    send_item(ptb_pkg::KIND_TICK, 24'($urandom()), $urandom());
  endtask

  // mostly well-formed traffic: creates with short periods, destroys of live
  // ids and ticks; some long periods, missing ids and ignored kinds mixed in
  task automatic test_random_traffic(input int n_items, input int snd_pct,
                                     input int rcv_pct);
    int          sent;
    int          pick;
    logic [23:0] iv;
    sent = 0;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      iv = ($urandom_range(9) == 0) ? 24'($urandom()) : 24'($urandom_range(6));
      if (pick < 35) begin
        send_item(ptb_pkg::KIND_TICK, 24'($urandom()), $urandom());
      end else if (pick < 65) begin
        send_item(ptb_pkg::KIND_CREATE, iv, $urandom());
      end else if (pick < 90) begin
        send_item(ptb_pkg::KIND_DESTROY, 24'($urandom()), random_live_ident());
      end else if (pick < 95) begin
        send_item(ptb_pkg::KIND_DESTROY, 24'($urandom()), $urandom());
      end else begin
        // ignored items do not count toward the item budget
        send_item(KIND_UNUSED, 24'($urandom()), $urandom());
        continue;
      end
      sent++;
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      bank_live[i]   = 1'b0;
      bank_ident[i]  = '0;
      bank_period[i] = '0;
      bank_left[i]   = '0;
    end
    serial_ctr = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part runs under the first idle mix
    test_create_and_expire();
    test_destroy();
    test_ignored_kind();
    test_bank_full();
    test_mass_expiry();

    // sender light / receiver heavy, then swapped, then no idling at all
    test_random_traffic(40, 27, 54);
    test_random_traffic(40, 54, 27);
    test_random_traffic(40, 0, 0);
    s_tvalid <= 1'b0;

    // drain: every owed result, then one sweep more for anything stray
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
